// File: hw/rtl/sliding_window_maximum_unit_assert.svh
// Assertion macros for the sliding window maximum unit.
`ifndef SLIDING_WINDOW_MAXIMUM_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_MAXIMUM_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SWM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("swm check failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define SWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("swm check failed");

`endif

// File: hw/rtl/swm_pkg.sv
// Shared constants, state encoding and control structs of the window maximum unit.
package swm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int WIN_MAX  = 64;
    localparam int AW       = $clog2(WIN_MAX);
    localparam int LEN_W    = AW + 1;
    localparam int CFG_W    = 7;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FRONT = 5'b00010,
        ST_POP   = 5'b00100,
        ST_PUSH  = 5'b01000,
        ST_OUT   = 5'b10000
    } t_state;

    typedef struct packed {
        logic accept;
        logic drop;
        logic pop;
        logic push;
        logic out_load;
        logic cq_rd_en;
    } t_cmd;

    typedef struct packed {
        logic front_match;
        logic pop_ok;
        logic result_due;
        logic out_free;
    } t_stat;

endpackage

// File: hw/rtl/swm_dp.sv
// Datapath: sample ring, candidate queue memory, counters and output register.
module swm_dp
    import swm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_stat                      o_stat,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_restart,
    input  logic                       i_cfg_we,
    input  logic [CFG_W-1:0]           i_cfg_wdata,
    input  logic                       i_out_stall,
    output logic                       o_out_valid,
    output logic signed [SAMPLE_W-1:0] o_window_max
);

    logic [SAMPLE_W-1:0] r_cq   [WIN_MAX];
    logic [SAMPLE_W-1:0] r_hist [WIN_MAX];

    logic signed [SAMPLE_W-1:0] r_sample, n_sample;
    logic [LEN_W-1:0]           r_len, n_len;
    logic [AW-1:0]              r_head, n_head;
    logic [AW-1:0]              r_wpos, n_wpos;
    logic [LEN_W-1:0]           r_fill, n_fill;
    logic [CFG_W-1:0]           r_win_size, n_win_size;
    logic                       r_front_new, n_front_new;
    logic                       r_out_valid, n_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_data, n_out_data;
    logic [SAMPLE_W-1:0]        r_cq_rd;
    logic [SAMPLE_W-1:0]        r_hist_rd;

    logic [LEN_W-1:0] win;
    logic [LEN_W-1:0] fill_inc;
    logic [LEN_W-1:0] len_p;
    logic [AW-1:0]    head_p;
    logic [AW-1:0]    hist_raddr;
    logic [AW-1:0]    cq_raddr;
    logic [AW-1:0]    cq_waddr;
    logic             cq_we;

    always_comb begin
        if (r_win_size == '0) begin
            win = LEN_W'(1);
        end else if (r_win_size > CFG_W'(WIN_MAX)) begin
            win = LEN_W'(WIN_MAX);
        end else begin
            win = LEN_W'(r_win_size);
        end
    end

    assign fill_inc   = (r_fill == LEN_W'(WIN_MAX)) ? r_fill : r_fill + LEN_W'(1);
    assign hist_raddr = r_wpos - win[AW-1:0];

    always_comb begin
        n_sample    = r_sample;
        n_len       = r_len;
        n_head      = r_head;
        n_wpos      = r_wpos;
        n_fill      = r_fill;
        n_front_new = r_front_new;
        head_p      = r_head;
        len_p       = r_len;
        cq_we       = 1'b0;
        cq_waddr    = r_head;
        n_win_size  = i_cfg_we ? i_cfg_wdata : r_win_size;

        if (i_cmd.accept) begin
            n_sample = i_sample;
            if (i_restart) begin
                n_len  = '0;
                n_fill = '0;
                n_wpos = '0;
            end
        end
        if (i_cmd.drop) begin
            n_head = r_head + AW'(1);
            n_len  = r_len - LEN_W'(1);
        end
        if (i_cmd.pop) begin
            n_len = r_len - LEN_W'(1);
        end
        if (i_cmd.push) begin
            // full queue: drop the oldest candidate so the sample still fits
            if (r_len == LEN_W'(WIN_MAX)) begin
                head_p = r_head + AW'(1);
                len_p  = r_len - LEN_W'(1);
            end
            cq_we       = 1'b1;
            cq_waddr    = head_p + len_p[AW-1:0];
            n_head      = head_p;
            n_len       = len_p + LEN_W'(1);
            n_front_new = (len_p == '0);
            n_wpos      = r_wpos + AW'(1);
            n_fill      = fill_inc;
        end

        // front after accept or push, otherwise the current back entry
        if (i_cmd.accept || i_cmd.push) begin
            cq_raddr = n_head;
        end else begin
            cq_raddr = n_head + n_len[AW-1:0] - AW'(1);
        end
    end

    assign o_stat.front_match = (r_fill >= win) && (r_len != '0) && (r_cq_rd == r_hist_rd);
    assign o_stat.pop_ok      = (r_len != '0) && ($signed(r_cq_rd) < r_sample);
    assign o_stat.result_due  = (fill_inc >= win);
    assign o_stat.out_free    = !r_out_valid || !i_out_stall;

    assign n_out_data  = i_cmd.out_load ? (r_front_new ? r_sample : $signed(r_cq_rd))
                                        : r_out_data;
    assign n_out_valid = i_cmd.out_load ? 1'b1 : (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_head      <= '0;
            r_wpos      <= '0;
            r_fill      <= '0;
            r_win_size  <= CFG_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_head      <= n_head;
            r_wpos      <= n_wpos;
            r_fill      <= n_fill;
            r_win_size  <= n_win_size;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sample    <= n_sample;
        r_front_new <= n_front_new;
        r_out_data  <= n_out_data;
    end

    always_ff @(posedge i_clk) begin
        if (cq_we) begin
            r_cq[cq_waddr] <= r_sample;
        end
        if (i_cmd.cq_rd_en) begin
            r_cq_rd <= r_cq[cq_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_hist[r_wpos] <= r_sample;
        end
        r_hist_rd <= r_hist[hist_raddr];
    end

    assign o_out_valid  = r_out_valid;
    assign o_window_max = r_out_data;

endmodule

// File: hw/rtl/swm_ctrl.sv
// Controller: sequences accept, front check, back pops, push and result load.
module swm_ctrl
    import swm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                o_cmd.cq_rd_en = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_FRONT;
                end
            end
            ST_FRONT: begin
                o_cmd.cq_rd_en = 1'b1;
                o_cmd.drop     = i_stat.front_match;
                n_state        = ST_POP;
            end
            ST_POP: begin
                o_cmd.cq_rd_en = 1'b1;
                if (i_stat.pop_ok) begin
                    o_cmd.pop = 1'b1;
                end else begin
                    n_state = ST_PUSH;
                end
            end
            ST_PUSH: begin
                o_cmd.cq_rd_en = 1'b1;
                o_cmd.push     = 1'b1;
                n_state        = i_stat.result_due ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: hw/rtl/sliding_window_maximum_unit.sv
// Samples are taken one at a time: o_in_stall stays high from each transfer until
//   its pops, push and any result load are done; the pop loop reads one queue
//   entry per cycle from the candidate memory.
// A result waiting in the output register does not block the next input transfer.
// Reset (i_rst_n low, synchronous): queue and window empty, window size 1,
//   no result pending; sample and queue memories keep their contents.
module sliding_window_maximum_unit
    import swm_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_restart,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_window_max,
    input  logic                       i_cfg_we,
    input  logic [CFG_W-1:0]           i_cfg_wdata
);

`include "sliding_window_maximum_unit_assert.svh"

    t_cmd  s_cmd;
    t_stat s_stat;

    // Controller walks each sample through: accept, drop a stale front,
    // pop smaller back entries one per cycle, push, then hand off the front once the window fills.
    swm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (s_stat),
        .o_cmd      (s_cmd)
    );

    // Datapath holds the ring of recent samples, the non-increasing candidate
    // queue (circular, head pointer plus length) and the output register.
    swm_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (s_cmd),
        .o_stat       (s_stat),
        .i_sample     (i_sample),
        .i_restart    (i_restart),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_window_max (o_window_max)
    );

    // A transfer always starts work, so the input side goes busy next cycle.
    `SWM_ASSERT_NEXT(a_accept_busy, i_in_valid && !o_in_stall, o_in_stall)
    // Never overwrite a result the consumer has not taken.
    `SWM_ASSERT_IMPL(a_load_free, s_cmd.out_load, (!o_out_valid || !i_out_stall))
    // Accept, drop, pop, push and result load are never issued together.
    `SWM_ASSERT_IMPL(a_one_op, 1'b1, ($onehot0({s_cmd.accept, s_cmd.drop, s_cmd.pop, s_cmd.push, s_cmd.out_load})))
    // A pop only follows a successful compare.
    `SWM_ASSERT_IMPL(a_pop_ok, s_cmd.pop, s_stat.pop_ok)

endmodule

// File: sim/tb.sv
// Self-checking testbench for the sliding window maximum unit.
module tb
    import swm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Random sample budget; the directed opening adds about twenty more.
    localparam int RANDOM_ITEMS   = 1530;
    // Settle wait covers the worst case: a full queue of pops plus the other controller states.
    localparam int SETTLE_CYCLES  = WIN_MAX + 16;
    // Quiet-spell limit, above a source gap, full pop loop, sink stall and settle together.
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       restart;
    } t_sample_item;

    // Shapes of random sample runs.
    typedef enum int {
        PAT_NOISE,
        PAT_FEW_LEVELS,
        PAT_FALLING,
        PAT_RISING,
        PAT_FLAT,
        PAT_RAILS
    } t_pattern;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_in_valid  = 1'b0;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_sample    = '0;
    logic                       i_restart   = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] o_window_max;
    logic                       i_cfg_we    = 1'b0;
    logic [CFG_W-1:0]           i_cfg_wdata = '0;

    sliding_window_maximum_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .i_restart    (i_restart),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_window_max (o_window_max),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // Samples waiting to be driven, and window maxima waiting to come out.
    t_sample_item               sample_backlog[$];
    logic signed [SAMPLE_W-1:0] max_due[$];

    // Shadow of the block: sample ring, candidate deque, counters, window register.
    logic signed [SAMPLE_W-1:0] ring_mem[WIN_MAX];
    logic signed [SAMPLE_W-1:0] cand_q[$];
    int unsigned                fill_cnt  = 0;
    int unsigned                wr_pos    = 0;
    logic [CFG_W-1:0]           win_reg   = CFG_W'(1);

    logic signed [SAMPLE_W-1:0] ramp_level = '0;
    int                         errors     = 0;
    int                         idle_cycles = 0;

    // Source and sink pacing state.
    int                         src_gap   = 0;
    int                         src_calm  = 0;
    int                         sink_left = 0;
    logic                       sink_hold = 1'b0;
    logic signed [SAMPLE_W-1:0] want;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hold reset low from the start, then release it for good.
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Effective window: zero acts as one, anything past the ring depth saturates.
    function automatic int unsigned span_of(input logic [CFG_W-1:0] v);
        if (v == '0) return 1;
        if (v > CFG_W'(WIN_MAX)) return WIN_MAX;
        return 32'(v);
    endfunction

    // Advance the shadow by one transferred sample and queue the maximum it yields.
    function automatic void take_sample(input logic signed [SAMPLE_W-1:0] s,
                                        input logic rs);
        int unsigned w;
        int unsigned slot;
        w = span_of(win_reg);
        if (rs) begin
            cand_q.delete();
            fill_cnt = 0;
            wr_pos   = 0;
        end
        // Drop the front if it is the sample now leaving the window.
        if (fill_cnt >= w) begin
            slot = (wr_pos + WIN_MAX - w) % WIN_MAX;
            if (cand_q.size() > 0 && cand_q[0] == ring_mem[slot])
                cand_q.delete(0);
        end
        // Remove every strictly smaller candidate from the back.
        while (cand_q.size() > 0 && cand_q[$] < s)
            cand_q.delete(cand_q.size() - 1);
        // A full deque only arises after a size change; discard the front to make room.
        if (cand_q.size() >= WIN_MAX)
            cand_q.delete(0);
        cand_q = {cand_q, s};
        ring_mem[wr_pos] = s;
        wr_pos = (wr_pos + 1) % WIN_MAX;
        if (fill_cnt < WIN_MAX)
            fill_cnt++;
        if (fill_cnt >= w)
            max_due = {max_due, cand_q[0]};
    endfunction

    task automatic queue_sample(input logic signed [SAMPLE_W-1:0] v, input logic rs);
        t_sample_item it;
        it.value   = v;
        it.restart = rs;
        sample_backlog = {sample_backlog, it};
    endtask

    // Queue a run of n samples of one shape; a fresh run opens with a restart.
    task automatic queue_run(input int n, input t_pattern pat, input bit fresh);
        logic signed [SAMPLE_W-1:0] v;
        int                         k;
        if (fresh) begin
            case (pat)
                PAT_FALLING: ramp_level = 16'sh7fff - SAMPLE_W'($urandom_range(0, 2000));
                PAT_RISING:  ramp_level = 16'sh8000 + SAMPLE_W'($urandom_range(0, 2000));
                default:     ramp_level = SAMPLE_W'($urandom);
            endcase
        end
        for (k = 0; k < n; k++) begin
            case (pat)
                PAT_NOISE:      v = SAMPLE_W'($urandom);
                PAT_FEW_LEVELS: v = SAMPLE_W'($urandom_range(0, 4) - 2);
                PAT_FALLING: begin
                    v = ramp_level;
                    ramp_level = ramp_level - SAMPLE_W'($urandom_range(1, 3));
                end
                PAT_RISING: begin
                    v = ramp_level;
                    ramp_level = ramp_level + SAMPLE_W'($urandom_range(0, 3));
                end
                PAT_FLAT:       v = ramp_level;
                default: begin
                    case ($urandom_range(0, 3))
                        0:       v = 16'sh8000;
                        1:       v = 16'sh7fff;
                        2:       v = -16'sd1;
                        default: v = '0;
                    endcase
                end
            endcase
            queue_sample(v, (k == 0 && fresh) || $urandom_range(0, 199) == 0);
        end
    endtask

    // Wait until every sample is in and every maximum is out, then let the
    // pop loop finish on samples that give no result.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (sample_backlog.size() != 0 || i_in_valid || max_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the window register while the block is quiet.
    task automatic write_window(input logic [CFG_W-1:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        win_reg      = v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stimulus: directed opening, a forced deque overflow, then random phases.
    initial begin
        int          random_items;
        int          segs;
        int          s;
        int          len;
        int unsigned w;
        bit          keep;
        logic [CFG_W-1:0] cfg;

        random_items = 0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);

        // Window size zero acts as one: every sample is its own maximum.
        write_window('0);
        queue_sample(16'sh8000, 1'b1);
        queue_sample(16'sh7fff, 1'b0);
        queue_sample('0,        1'b0);
        queue_sample(-16'sd1,   1'b0);
        queue_sample(16'sd1,    1'b0);
        queue_sample(16'sd5,    1'b0);
        queue_sample(16'sd5,    1'b0);
        wait_idle();

        // Window of three: a short sequence cut by a restart gives nothing,
        // then a repeated maximum leaves the window while its twin stays.
        write_window(CFG_W'(3));
        queue_sample(16'sd7,  1'b1);
        queue_sample(16'sd2,  1'b0);
        queue_sample(16'sd3,  1'b1);
        queue_sample(16'sd1,  1'b0);
        queue_sample(16'sd3,  1'b0);
        queue_sample(16'sd2,  1'b0);
        queue_sample('0,      1'b0);
        queue_sample(-16'sd4, 1'b0);
        wait_idle();

        // Shrink the window without a restart.
        write_window(CFG_W'(2));
        queue_sample(-16'sd5, 1'b0);
        queue_sample(16'sd6,  1'b0);
        queue_sample(-16'sd7, 1'b0);
        queue_sample(16'sd8,  1'b0);
        wait_idle();

        // Fill the deque with a falling ramp at full width, then cut the window
        // to one without a restart so the deque overflows on append.
        write_window(CFG_W'(WIN_MAX));
        queue_run(WIN_MAX + 6, PAT_FALLING, 1'b1);
        wait_idle();
        write_window(CFG_W'(1));
        queue_run(10, PAT_FALLING, 1'b0);
        random_items += WIN_MAX + 16;

        while (random_items < RANDOM_ITEMS) begin
            wait_idle();
            case ($urandom_range(0, 9))
                0:       cfg = '0;
                1:       cfg = CFG_W'(1);
                2:       cfg = CFG_W'(WIN_MAX);
                3:       cfg = CFG_W'(127);
                4:       cfg = CFG_W'($urandom_range(WIN_MAX + 1, 126));
                5, 6:    cfg = CFG_W'($urandom_range(17, WIN_MAX - 1));
                default: cfg = CFG_W'($urandom_range(2, 16));
            endcase
            write_window(cfg);
            w    = span_of(cfg);
            // Now and then carry the old window across the size change.
            keep = ($urandom_range(0, 3) == 0);
            segs = $urandom_range(1, 4);
            for (s = 0; s < segs; s++) begin
                // Mostly full windows and beyond; some runs stop short.
                if ($urandom_range(0, 4) == 0)
                    len = $urandom_range(1, w);
                else
                    len = w + $urandom_range(0, 60);
                queue_run(len, t_pattern'($urandom_range(0, 5)), !(s == 0 && keep));
                random_items += len;
            end
        end

        wait_idle();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Driver: present backlog samples, hold each until its transfer, and
    // insert random gaps between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                take_sample(i_sample, i_restart);
            // The slot frees up when nothing is held or the held sample just went.
            if (!i_in_valid || !o_in_stall) begin
                if (src_gap > 0) begin
                    src_gap--;
                    i_in_valid <= 1'b0;
                end else if (sample_backlog.size() != 0) begin
                    t_sample_item it;
                    it = sample_backlog[0];
                    sample_backlog.delete(0);
                    i_sample   <= it.value;
                    i_restart  <= it.restart;
                    i_in_valid <= 1'b1;
                    // Pick the gap before the next sample: mostly none or short,
                    // a few long, with calm stretches of back-to-back transfers.
                    if (src_calm > 0) begin
                        src_calm--;
                        src_gap = 0;
                    end else begin
                        case ($urandom_range(0, 99)) inside
                            [0:1]:   src_calm = $urandom_range(20, 100);
                            [2:59]:  src_gap  = 0;
                            [60:91]: src_gap  = $urandom_range(1, 3);
                            default: src_gap  = $urandom_range(4, 40);
                        endcase
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each transferred maximum with the oldest one due, and
    // stall the output at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (max_due.size() == 0) begin
                    $display("%0t: window max %0d arrived with none due", $time,
                             o_window_max);
                    errors++;
                end else begin
                    want = max_due[0];
                    max_due.delete(0);
                    if (o_window_max !== want) begin
                        $display("%0t: window max expected %0d, got %0d", $time,
                                 want, o_window_max);
                        errors++;
                    end
                end
            end
            // Advance the stall pattern: short runs, long stalls now and then,
            // and long free stretches.
            if (sink_left > 0) begin
                sink_left--;
            end else begin
                case ($urandom_range(0, 99)) inside
                    [0:54]:  begin sink_hold = 1'b0; sink_left = $urandom_range(0, 7);    end
                    [55:69]: begin sink_hold = 1'b0; sink_left = $urandom_range(50, 200); end
                    [70:91]: begin sink_hold = 1'b1; sink_left = $urandom_range(0, 2);    end
                    default: begin sink_hold = 1'b1; sink_left = $urandom_range(10, 40);  end
                endcase
            end
            i_out_stall <= sink_hold;
        end
    end

    // Watchdog: end the run if nothing transfers for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
